### rtl/pphdr_pkg.sv
// shared types and constants of the raw ppm header parser
`default_nettype none

package pphdr_pkg;

    localparam int DIM_BITS_DEFAULT = 16;
    localparam int OUT_DIM_BITS     = 16;
    localparam int STATUS_BITS      = 3;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_EOS        = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BAD_MAGIC  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD_CHAR   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_BAD_MAXVAL = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_TRUNCATED  = 3'd5;
    localparam logic [STATUS_BITS-1:0] ST_TOO_LARGE  = 3'd6;

    localparam logic [7:0] CH_MAGIC0  = 8'h50;
    localparam logic [7:0] CH_MAGIC1  = 8'h36;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0d;

    localparam int MAXVAL = 255;

    typedef enum logic [8:0] {
        PH_MAGIC0 = 9'b000000001,
        PH_MAGIC1 = 9'b000000010,
        PH_MAGIC2 = 9'b000000100,
        PH_SKIP_W = 9'b000001000,
        PH_NUM_W  = 9'b000010000,
        PH_SKIP_H = 9'b000100000,
        PH_NUM_H  = 9'b001000000,
        PH_SKIP_M = 9'b010000000,
        PH_NUM_M  = 9'b100000000
    } phase_t;

endpackage

`default_nettype wire

### rtl/ppm_raw_header_parser.sv
// raw ppm (p6) header parser, one header byte per item
//
// input channel: in_valid / in_stall with data_byte and end_of_input.
// an item with end_of_input set carries no byte and closes the stream.
// output channel: out_valid / out_stall with status, image_width and
// image_height; one item leaves per finished or failed header.
// a byte is registered at the input, decoded by one pass of logic against
// the parser state, and any result lands in the output register.
// throughput is one byte per cycle while no result waits on a stalled
// receiver; the state update and the times-ten accumulate of the digit
// path sit in that single pass.
// while the receiver stalls, bytes that give no result keep flowing;
// a byte that would give a result waits in the input register and
// in_stall rises until the pending result is taken.
// reset clears both registers' valid flags and returns the parser to
// waiting for the first magic byte; after every result it rearms the same way.
`default_nettype none

module ppm_raw_header_parser #(
    parameter int DIM_BITS = pphdr_pkg::DIM_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [7:0]                            data_byte,
    input  wire logic                                  end_of_input,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [pphdr_pkg::STATUS_BITS-1:0]          status,
    output logic [pphdr_pkg::OUT_DIM_BITS-1:0]         image_width,
    output logic [pphdr_pkg::OUT_DIM_BITS-1:0]         image_height
);

    import pphdr_pkg::*;

    localparam int ACC_BITS = DIM_BITS + 4;
    localparam logic [ACC_BITS-1:0] LIMIT = {{4{1'b0}}, {DIM_BITS{1'b1}}};

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;

    // parser state
    phase_t              phase_reg, phase_next;
    logic                in_comment_reg, in_comment_next;
    logic                mismatch_reg, mismatch_next;
    logic [DIM_BITS-1:0] acc_reg, acc_next;
    logic [DIM_BITS-1:0] width_hold_reg, width_hold_next;
    logic [DIM_BITS-1:0] height_hold_reg, height_hold_next;

    // result register
    logic                    out_valid_reg;
    logic [STATUS_BITS-1:0]  status_reg;
    logic [OUT_DIM_BITS-1:0] width_out_reg;
    logic [OUT_DIM_BITS-1:0] height_out_reg;

    logic                    produce;
    logic [STATUS_BITS-1:0]  res_status;
    logic [OUT_DIM_BITS-1:0] res_width;
    logic [OUT_DIM_BITS-1:0] res_height;
    logic                    advance;
    logic                    out_load;
    logic                    in_accept;

    logic                    is_ws;
    logic                    is_digit;
    logic [ACC_BITS-1:0]     digit_ext;
    logic [ACC_BITS-1:0]     acc_ext;
    logic [ACC_BITS-1:0]     acc_times_ten;
    logic [DIM_BITS+OUT_DIM_BITS-1:0] width_wide;
    logic [DIM_BITS+OUT_DIM_BITS-1:0] height_wide;

    assign is_ws    = s1_byte_reg inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign is_digit = s1_byte_reg inside {[CH_ZERO:CH_NINE]};

    assign digit_ext     = ACC_BITS'(s1_byte_reg - CH_ZERO) & ACC_BITS'(4'hf);
    assign acc_ext       = ACC_BITS'(acc_reg);
    assign acc_times_ten = (acc_ext << 3) + (acc_ext << 1) + digit_ext;

    assign width_wide  = {{OUT_DIM_BITS{1'b0}}, width_hold_reg};
    assign height_wide = {{OUT_DIM_BITS{1'b0}}, height_hold_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        in_comment_next  = in_comment_reg;
        mismatch_next    = mismatch_reg;
        acc_next         = acc_reg;
        width_hold_next  = width_hold_reg;
        height_hold_next = height_hold_reg;
        produce          = 1'b0;
        res_status       = ST_OK;
        res_width        = '0;
        res_height       = '0;

        if (s1_end_reg)
        begin
            produce = 1'b1;
            if (phase_reg == PH_MAGIC1 || phase_reg == PH_MAGIC2 ||
                !(phase_reg inside {PH_SKIP_W, PH_NUM_W, PH_SKIP_H, PH_NUM_H,
                                    PH_SKIP_M, PH_NUM_M}))
            begin
                res_status = ST_EOS;
            end
            else
            begin
                res_status = ST_TRUNCATED;
            end
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC1:
                begin
                    if (s1_byte_reg != CH_MAGIC1)
                    begin
                        mismatch_next = 1'b1;
                    end
                    phase_next = PH_MAGIC2;
                end
                PH_MAGIC2:
                begin
                    if (mismatch_reg)
                    begin
                        produce    = 1'b1;
                        res_status = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        in_comment_next = 1'b0;
                        phase_next      = PH_SKIP_W;
                    end
                end
                PH_SKIP_W, PH_SKIP_H, PH_SKIP_M:
                begin
                    if (is_ws || s1_byte_reg == CH_HASH || in_comment_reg)
                    begin
                        if (s1_byte_reg == CH_HASH)
                        begin
                            in_comment_next = 1'b1;
                        end
                        if (s1_byte_reg == CH_NEWLINE)
                        begin
                            in_comment_next = 1'b0;
                        end
                    end
                    else if (!is_digit)
                    begin
                        produce    = 1'b1;
                        res_status = ST_BAD_CHAR;
                    end
                    else
                    begin
                        acc_next = DIM_BITS'(digit_ext);
                        case (phase_reg)
                            PH_SKIP_W: phase_next = PH_NUM_W;
                            PH_SKIP_H: phase_next = PH_NUM_H;
                            default:   phase_next = PH_NUM_M;
                        endcase
                    end
                end
                PH_NUM_W, PH_NUM_H, PH_NUM_M:
                begin
                    if (is_ws)
                    begin
                        if (phase_reg == PH_NUM_W)
                        begin
                            width_hold_next = acc_reg;
                            in_comment_next = 1'b0;
                            phase_next      = PH_SKIP_H;
                        end
                        else if (phase_reg == PH_NUM_H)
                        begin
                            height_hold_next = acc_reg;
                            in_comment_next  = 1'b0;
                            phase_next       = PH_SKIP_M;
                        end
                        else if (acc_reg != DIM_BITS'(MAXVAL))
                        begin
                            produce    = 1'b1;
                            res_status = ST_BAD_MAXVAL;
                        end
                        else
                        begin
                            produce    = 1'b1;
                            res_status = ST_OK;
                            res_width  = width_wide[OUT_DIM_BITS-1:0];
                            res_height = height_wide[OUT_DIM_BITS-1:0];
                        end
                    end
                    else if (!is_digit)
                    begin
                        produce    = 1'b1;
                        res_status = ST_BAD_CHAR;
                    end
                    else if (acc_times_ten > LIMIT)
                    begin
                        produce    = 1'b1;
                        res_status = ST_TOO_LARGE;
                    end
                    else
                    begin
                        acc_next = acc_times_ten[DIM_BITS-1:0];
                    end
                end
                default:
                begin
                    // first magic byte, also any code with no meaning
                    mismatch_next = (s1_byte_reg != CH_MAGIC0);
                    phase_next    = PH_MAGIC1;
                end
            endcase
        end

        if (produce)
        begin
            phase_next       = PH_MAGIC0;
            in_comment_next  = 1'b0;
            mismatch_next    = 1'b0;
            acc_next         = '0;
            width_hold_next  = '0;
            height_hold_next = '0;
        end
    end

    assign advance   = s1_valid_reg && (!produce || !out_valid_reg || !out_stall);
    assign out_load  = advance && produce;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_MAGIC0;
            in_comment_reg  <= 1'b0;
            mismatch_reg    <= 1'b0;
            acc_reg         <= '0;
            width_hold_reg  <= '0;
            height_hold_reg <= '0;
        end
        else
        begin
            s1_valid_reg  <= in_accept || (s1_valid_reg && !advance);
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            if (advance)
            begin
                phase_reg       <= phase_next;
                in_comment_reg  <= in_comment_next;
                mismatch_reg    <= mismatch_next;
                acc_reg         <= acc_next;
                width_hold_reg  <= width_hold_next;
                height_hold_reg <= height_hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= data_byte;
            s1_end_reg  <= end_of_input;
        end
        if (out_load)
        begin
            status_reg     <= res_status;
            width_out_reg  <= res_width;
            height_out_reg <= res_height;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign image_width  = width_out_reg;
    assign image_height = height_out_reg;

    // stall only holds back a byte already registered
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // failures carry zero dimensions
    a_fail_zero_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |->
            (width_out_reg == '0 && height_out_reg == '0))
        else $error("failed header reported nonzero dimensions");

    // parser rearms after every result
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (phase_reg == PH_MAGIC0 && acc_reg == '0 && !mismatch_reg))
        else $error("parser did not rearm after a result");

    // a taken result without a new one empties the output register
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !out_load) |=> !out_valid_reg)
        else $error("result delivered twice");

endmodule

`default_nettype wire
